/* rtl/wsfp_pkg.sv */
`default_nettype none

package wsfp_pkg;

   typedef enum logic [2:0] {
      PH_HDR0    = 3'd0,
      PH_HDR1    = 3'd1,
      PH_EXTLEN  = 3'd2,
      PH_KEY     = 3'd3,
      PH_PAYLOAD = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      ST_DATA   = 2'd0,
      ST_TRUNC  = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_ORPHAN = 2'd3
   } status_type;

   localparam logic [3:0] OP_CONT   = 4'h0;
   localparam logic [3:0] OP_TEXT   = 4'h1;
   localparam logic [3:0] OP_BINARY = 4'h2;

   localparam logic [6:0] SHORT_LEN_MAX = 7'd125;
   localparam logic [6:0] LEN_CODE_16   = 7'd126;

   localparam logic [3:0] KEY_BYTES   = 4'd4;
   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;

endpackage

`default_nettype wire

/* rtl/wsfp_req_if.sv */
`default_nettype none

interface wsfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       buffer_end;

   modport source (output valid, output rx_byte, output buffer_end, input ready);
   modport sink   (input valid, input rx_byte, input buffer_end, output ready);
endinterface

`default_nettype wire

/* rtl/wsfp_rsp_if.sv */
`default_nettype none

interface wsfp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] payload_byte;
   logic [3:0] message_opcode;
   logic       final_fragment;
   logic       frame_last;
   logic [1:0] status;

   modport source (output valid, output payload_byte, output message_opcode,
                   output final_fragment, output frame_last, output status,
                   input ready);
   modport sink   (input valid, input payload_byte, input message_opcode,
                   input final_fragment, input frame_last, input status,
                   output ready);
endinterface

`default_nettype wire

/* rtl/websocket_frame_parser.sv */
`default_nettype none

// WebSocket receive deframer.
// req_ch carries the received stream one byte per transaction, with
// buffer_end set on the last byte of a received buffer. rsp_ch carries at
// most one result per byte: an unmasked payload byte, or a status result for
// an empty frame, a dropped orphan continuation or a truncated frame.
// A continuation frame reports the opcode of the open text or binary message.
// An accepted byte waits in the input register, and its result is offered
// from the result register. Throughput: one byte per cycle while rsp_ch does
// not stall; the header parse, the LENGTH_WIDTH-bit length decrement and the
// unmask all fit between the input and result registers. If rsp_ch stalls,
// the result register holds and the input register still takes one more
// byte; req_ch.ready drops only when both are full.
// Reset clears the frame state: parsing restarts at a header byte, no message
// is open and both registers are empty.
module websocket_frame_parser #(
   parameter int LENGTH_WIDTH = 64
) (
   input wire logic   clock,
   input wire logic   reset,
   wsfp_req_if.sink   req_ch,
   wsfp_rsp_if.source rsp_ch
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_end_ff;

   // parser state
   wsfp_pkg::phase_type     phase_ff, phase_in, phase_pre;
   logic                    fin_ff, fin_in;
   logic [3:0]              op_ff, op_in;
   logic                    mask_ff, mask_in;
   logic [3:0]              cnt_ff, cnt_in;
   logic [LENGTH_WIDTH-1:0] rem_ff, rem_in;
   logic [31:0]             key_ff, key_in;
   logic [1:0]              kpos_ff, kpos_in;
   logic [3:0]              open_ff, open_in;
   logic                    drop_ff, drop_in;

   // result register
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff;
   logic [3:0] out_op_ff;
   logic       out_fin_ff;
   logic       out_last_ff;
   logic [1:0] out_status_ff;

   logic                    out_free, proc_go, req_take;
   logic [6:0]              byte_len;
   logic [3:0]              cnt_dec;
   logic [LENGTH_WIDTH-1:0] rem_dec, ext_len;
   logic                    pay_last;
   logic                    hdr_done, hdr_empty, hdr_drop, trunc;
   logic                    open_known;
   logic [7:0]              key_byte;

   logic                   res_valid;
   logic [7:0]             res_byte;
   logic                   res_last;
   wsfp_pkg::status_type   res_status;

   assign out_free = !out_valid_ff || rsp_ch.ready;
   assign proc_go  = in_valid_ff && out_free;
   assign req_ch.ready = !in_valid_ff || out_free;
   assign req_take = req_ch.valid && req_ch.ready;

   assign byte_len   = in_byte_ff[6:0];
   assign cnt_dec    = cnt_ff - 4'd1;
   assign rem_dec    = rem_ff - {{(LENGTH_WIDTH-1){1'b0}}, 1'b1};
   assign pay_last   = (rem_dec == '0);
   assign open_known = (open_ff == wsfp_pkg::OP_TEXT) || (open_ff == wsfp_pkg::OP_BINARY);

   wsfp_len_acc #(
      .LENGTH_WIDTH (LENGTH_WIDTH)
   ) u_len_acc (
      .len_cur  (rem_ff),
      .byte_in  (in_byte_ff),
      .len_next (ext_len)
   );

   always_comb begin
      unique case (kpos_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   // next state
   always_comb begin
      phase_pre = phase_ff;
      fin_in    = fin_ff;
      op_in     = op_ff;
      mask_in   = mask_ff;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      key_in    = key_ff;
      kpos_in   = kpos_ff;
      open_in   = open_ff;
      drop_in   = drop_ff;
      hdr_done  = 1'b0;
      hdr_empty = 1'b0;
      hdr_drop  = 1'b0;

      if (proc_go) begin
         unique case (phase_ff)
            wsfp_pkg::PH_HDR0: begin
               fin_in    = in_byte_ff[7];
               op_in     = in_byte_ff[3:0];
               drop_in   = 1'b0;
               rem_in    = '0;
               key_in    = '0;
               cnt_in    = '0;
               kpos_in   = '0;
               phase_pre = wsfp_pkg::PH_HDR1;
            end
            wsfp_pkg::PH_HDR1: begin
               mask_in = in_byte_ff[7];
               if (byte_len <= wsfp_pkg::SHORT_LEN_MAX) begin
                  rem_in = {{(LENGTH_WIDTH-7){1'b0}}, byte_len};
                  if (in_byte_ff[7]) begin
                     cnt_in    = wsfp_pkg::KEY_BYTES;
                     phase_pre = wsfp_pkg::PH_KEY;
                  end else begin
                     hdr_done = 1'b1;
                  end
               end else begin
                  rem_in    = '0;
                  cnt_in    = (byte_len == wsfp_pkg::LEN_CODE_16) ?
                              wsfp_pkg::EXT16_BYTES : wsfp_pkg::EXT64_BYTES;
                  phase_pre = wsfp_pkg::PH_EXTLEN;
               end
            end
            wsfp_pkg::PH_EXTLEN: begin
               rem_in = ext_len;
               cnt_in = cnt_dec;
               if (cnt_dec == '0) begin
                  if (mask_ff) begin
                     cnt_in    = wsfp_pkg::KEY_BYTES;
                     phase_pre = wsfp_pkg::PH_KEY;
                  end else begin
                     hdr_done = 1'b1;
                  end
               end
            end
            wsfp_pkg::PH_KEY: begin
               key_in = {key_ff[23:0], in_byte_ff};
               cnt_in = cnt_dec;
               if (cnt_dec == '0) begin
                  hdr_done = 1'b1;
               end
            end
            wsfp_pkg::PH_PAYLOAD: begin
               rem_in = rem_dec;
               if (pay_last) begin
                  phase_pre = wsfp_pkg::PH_HDR0;
               end
               if (drop_ff) begin
                  if (pay_last) begin
                     drop_in = 1'b0;
                  end
               end else begin
                  kpos_in = kpos_ff + 2'd1;
               end
            end
            default: begin
               phase_pre = wsfp_pkg::PH_HDR0;
            end
         endcase

         // header complete: resolve continuation and track the open message
         if (hdr_done) begin
            if (op_ff == wsfp_pkg::OP_CONT) begin
               if (open_known) begin
                  op_in = open_ff;
                  if (fin_ff) begin
                     open_in = wsfp_pkg::OP_CONT;
                  end
               end else begin
                  drop_in  = 1'b1;
                  hdr_drop = 1'b1;
               end
            end else if (op_ff == wsfp_pkg::OP_TEXT || op_ff == wsfp_pkg::OP_BINARY) begin
               open_in = fin_ff ? wsfp_pkg::OP_CONT : op_ff;
            end
            kpos_in = '0;
            if (rem_in == '0) begin
               hdr_empty = 1'b1;
               drop_in   = 1'b0;
               phase_pre = wsfp_pkg::PH_HDR0;
            end else begin
               phase_pre = wsfp_pkg::PH_PAYLOAD;
            end
         end
      end

      trunc    = proc_go && in_end_ff && (phase_pre != wsfp_pkg::PH_HDR0);
      phase_in = trunc ? wsfp_pkg::PH_HDR0 : phase_pre;
      if (trunc) begin
         drop_in = 1'b0;
      end
   end

   // result of the current byte
   always_comb begin
      res_valid  = 1'b0;
      res_byte   = '0;
      res_last   = 1'b1;
      res_status = wsfp_pkg::ST_DATA;
      priority if (trunc) begin
         res_valid  = 1'b1;
         res_status = wsfp_pkg::ST_TRUNC;
      end else if (hdr_done && hdr_empty) begin
         res_valid  = 1'b1;
         res_status = hdr_drop ? wsfp_pkg::ST_ORPHAN : wsfp_pkg::ST_EMPTY;
      end else if (proc_go && phase_ff == wsfp_pkg::PH_PAYLOAD) begin
         if (drop_ff) begin
            res_valid  = pay_last;
            res_status = wsfp_pkg::ST_ORPHAN;
         end else begin
            res_valid = 1'b1;
            res_byte  = in_byte_ff ^ (mask_ff ? key_byte : 8'h00);
            res_last  = pay_last;
         end
      end
   end

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (proc_go) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_comb begin
      if (proc_go) begin
         out_valid_in = res_valid;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= wsfp_pkg::PH_HDR0;
         open_ff      <= wsfp_pkg::OP_CONT;
         drop_ff      <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
         open_ff      <= open_in;
         drop_ff      <= drop_in;
      end
   end

   // frame fields are rewritten by the header bytes, so they need no reset
   always_ff @(posedge clock) begin
      fin_ff  <= fin_in;
      op_ff   <= op_in;
      mask_ff <= mask_in;
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      key_ff  <= key_in;
      kpos_ff <= kpos_in;
      if (req_take) begin
         in_byte_ff <= req_ch.rx_byte;
         in_end_ff  <= req_ch.buffer_end;
      end
      if (proc_go && res_valid) begin
         out_byte_ff   <= res_byte;
         out_op_ff     <= op_in;
         out_fin_ff    <= fin_in;
         out_last_ff   <= res_last;
         out_status_ff <= res_status;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.payload_byte   = out_byte_ff;
   assign rsp_ch.message_opcode = out_op_ff;
   assign rsp_ch.final_fragment = out_fin_ff;
   assign rsp_ch.frame_last     = out_last_ff;
   assign rsp_ch.status         = out_status_ff;

   a_status_zero_byte : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_status_ff != wsfp_pkg::ST_DATA) |->
         (out_byte_ff == 8'h00 && out_last_ff))
      else $error("status result carries a payload byte or lacks frame_last");

   a_trunc_restart : assert property (@(posedge clock) disable iff (reset)
      trunc |=> (phase_ff == wsfp_pkg::PH_HDR0 && !drop_ff))
      else $error("truncation did not restart the header parse");

   a_drop_in_payload : assert property (@(posedge clock) disable iff (reset)
      drop_ff |-> (phase_ff == wsfp_pkg::PH_PAYLOAD))
      else $error("orphan drop flag set outside a payload");

   a_open_opcode : assert property (@(posedge clock) disable iff (reset)
      (open_ff == wsfp_pkg::OP_CONT || open_ff == wsfp_pkg::OP_TEXT ||
       open_ff == wsfp_pkg::OP_BINARY))
      else $error("open message opcode is not text or binary");

endmodule

`default_nettype wire

/* rtl/wsfp_len_acc.sv */
`default_nettype none

// Shift one byte of an extended length into the accumulator, network byte
// order, saturating at the all-ones value once the top byte is occupied.
module wsfp_len_acc #(
   parameter int LENGTH_WIDTH = 64
) (
   input  wire logic [LENGTH_WIDTH-1:0] len_cur,
   input  wire logic [7:0]              byte_in,
   output      logic [LENGTH_WIDTH-1:0] len_next
);

   always_comb begin
      if (|len_cur[LENGTH_WIDTH-1 -: 8]) begin
         len_next = '1;
      end else begin
         len_next = {len_cur[LENGTH_WIDTH-9:0], byte_in};
      end
   end

endmodule

`default_nettype wire

/* tb/tb_top.sv */
module tb_top;
   import wsfp_pkg::*;

   localparam int LEN_W = 64;
   localparam logic [LEN_W-1:0] LEN_MAX = '1;
   localparam logic [6:0] LEN_CODE_64 = 7'd127;
   localparam logic [3:0] NO_MESSAGE = 4'h0;
   localparam logic [3:0] OP_PING = 4'hA;
   localparam logic [3:0] OP_CTRL_RSVD = 4'hF;
   localparam int RANDOM_ITEMS = 1300;
   localparam int QUIET_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 8;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic [3:0] message_opcode;
      logic       final_fragment;
      logic       frame_last;
      status_type status;
   } result_t;

   typedef struct packed {
      logic [7:0] rx;
      logic       buf_end;
      logic       pinned;
      logic       pin_got;
      result_t    pin;
   } stim_row_t;

   localparam result_t NO_RSP = '{8'h00, 4'h0, 1'b0, 1'b0, ST_DATA};

   // Rows with pinned set carry their expected result; the rest use the predictor.
   localparam stim_row_t STIM_TABLE [24] = '{
      '{8'h81, 1'b0, 1'b1, 1'b0, NO_RSP},
      '{8'h00, 1'b0, 1'b1, 1'b1, '{8'h00, OP_TEXT, 1'b1, 1'b1, ST_EMPTY}},
      '{8'h80, 1'b0, 1'b1, 1'b0, NO_RSP},
      '{8'h00, 1'b0, 1'b1, 1'b1, '{8'h00, OP_CONT, 1'b1, 1'b1, ST_ORPHAN}},
      '{8'h01, 1'b0, 1'b0, 1'b0, NO_RSP},
      '{8'h82, 1'b0, 1'b0, 1'b0, NO_RSP},
      '{8'hA5, 1'b0, 1'b0, 1'b0, NO_RSP},
      '{8'h5A, 1'b0, 1'b0, 1'b0, NO_RSP},
      '{8'hFF, 1'b0, 1'b0, 1'b0, NO_RSP},
      '{8'h00, 1'b0, 1'b0, 1'b0, NO_RSP},
      '{8'h3C, 1'b0, 1'b0, 1'b0, NO_RSP},
      '{8'hC3, 1'b0, 1'b0, 1'b0, NO_RSP},
      '{8'h80, 1'b0, 1'b0, 1'b0, NO_RSP},
      '{8'h01, 1'b0, 1'b0, 1'b0, NO_RSP},
      '{8'hFF, 1'b0, 1'b0, 1'b0, NO_RSP},
      '{8'h82, 1'b0, 1'b0, 1'b0, NO_RSP},
      '{8'h7E, 1'b0, 1'b0, 1'b0, NO_RSP},
      '{8'h00, 1'b0, 1'b0, 1'b0, NO_RSP},
      '{8'h01, 1'b0, 1'b0, 1'b0, NO_RSP},
      '{8'hAB, 1'b0, 1'b0, 1'b0, NO_RSP},
      '{8'h8A, 1'b0, 1'b0, 1'b0, NO_RSP},
      '{8'h7D, 1'b0, 1'b0, 1'b0, NO_RSP},
      '{8'h00, 1'b1, 1'b1, 1'b1, '{8'h00, OP_PING, 1'b1, 1'b1, ST_TRUNC}},
      '{8'hFF, 1'b1, 1'b1, 1'b1, '{8'h00, OP_CTRL_RSVD, 1'b1, 1'b1, ST_TRUNC}}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   wsfp_req_if req_ch();
   wsfp_rsp_if rsp_ch();

   websocket_frame_parser #(.LENGTH_WIDTH(LEN_W)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Deframer state as the block should hold it
   phase_type        frame_phase = PH_HDR0;
   logic             hdr_fin = 1'b0;
   logic [3:0]       hdr_opcode = 4'h0;
   logic             hdr_masked = 1'b0;
   logic [3:0]       field_left = 4'h0;
   logic [LEN_W-1:0] bytes_left = '0;
   logic [31:0]      unmask_key = '0;
   logic [1:0]       key_index = 2'd0;
   logic [3:0]       msg_opcode = NO_MESSAGE;
   logic             orphan_frame = 1'b0;

   result_t pending_results[$];
   int      mismatches = 0;
   int      quiet_cycles = 0;
   bit      sender_eager = 1'b0;

   function automatic result_t result_of(logic [7:0] pb, status_type st, logic last);
      return '{pb, hdr_opcode, hdr_fin, last, st};
   endfunction

   function automatic bit header_done(output result_t r);
      if (hdr_opcode == OP_CONT) begin
         if (msg_opcode == OP_TEXT || msg_opcode == OP_BINARY) begin
            hdr_opcode = msg_opcode;
            if (hdr_fin) msg_opcode = NO_MESSAGE;
         end else begin
            orphan_frame = 1'b1;
         end
      end else if (hdr_opcode == OP_TEXT || hdr_opcode == OP_BINARY) begin
         msg_opcode = hdr_fin ? NO_MESSAGE : hdr_opcode;
      end
      key_index = 2'd0;
      if (bytes_left == 0) begin
         frame_phase = PH_HDR0;
         if (orphan_frame) begin
            orphan_frame = 1'b0;
            r = result_of(8'h00, ST_ORPHAN, 1'b1);
         end else begin
            r = result_of(8'h00, ST_EMPTY, 1'b1);
         end
         return 1'b1;
      end
      frame_phase = PH_PAYLOAD;
      return 1'b0;
   endfunction

   function automatic bit length_done(output result_t r);
      if (hdr_masked) begin
         field_left = KEY_BYTES;
         frame_phase = PH_KEY;
         return 1'b0;
      end
      return header_done(r);
   endfunction

   function automatic bit deframe_step(logic [7:0] rx, logic buf_end, output result_t r);
      bit   got;
      logic last;
      got = 1'b0;
      r = NO_RSP;
      case (frame_phase)
         PH_HDR0: begin
            hdr_fin = rx[7];
            hdr_opcode = rx[3:0];
            orphan_frame = 1'b0;
            bytes_left = '0;
            unmask_key = '0;
            field_left = 4'h0;
            key_index = 2'd0;
            frame_phase = PH_HDR1;
         end
         PH_HDR1: begin
            hdr_masked = rx[7];
            if (rx[6:0] <= SHORT_LEN_MAX) begin
               bytes_left = LEN_W'(rx[6:0]);
               got = length_done(r);
            end else begin
               bytes_left = '0;
               field_left = (rx[6:0] == LEN_CODE_16) ? EXT16_BYTES : EXT64_BYTES;
               frame_phase = PH_EXTLEN;
            end
         end
         PH_EXTLEN: begin
            // saturate a length that will not fit
            if (bytes_left > (LEN_MAX >> 8)) bytes_left = LEN_MAX;
            else bytes_left = {bytes_left[LEN_W-9:0], rx};
            field_left = field_left - 4'd1;
            if (field_left == 0) got = length_done(r);
         end
         PH_KEY: begin
            unmask_key = {unmask_key[23:0], rx};
            field_left = field_left - 4'd1;
            if (field_left == 0) got = header_done(r);
         end
         default: begin
            bytes_left = bytes_left - LEN_W'(1);
            last = (bytes_left == 0);
            if (last) frame_phase = PH_HDR0;
            if (orphan_frame) begin
               if (last) begin
                  orphan_frame = 1'b0;
                  r = result_of(8'h00, ST_ORPHAN, 1'b1);
                  got = 1'b1;
               end
            end else begin
               r = result_of(hdr_masked ? rx ^ unmask_key[8*(3-key_index) +: 8] : rx,
                             ST_DATA, last);
               got = 1'b1;
               key_index = key_index + 2'd1;
            end
         end
      endcase
      if (buf_end && frame_phase != PH_HDR0) begin
         frame_phase = PH_HDR0;
         orphan_frame = 1'b0;
         r = result_of(8'h00, ST_TRUNC, 1'b1);
         got = 1'b1;
      end
      return got;
   endfunction

   function automatic int pick_idle();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   task automatic send_byte(input logic [7:0] rx, input logic buf_end, input bit hold,
                            input logic pinned, input logic pin_got, input result_t pin);
      result_t r;
      bit      got;
      int      gap;
      got = deframe_step(rx, buf_end, r);
      if (pinned) begin
         got = pin_got;
         r = pin;
      end
      if (got) pending_results.push_back(r);
      req_ch.valid <= 1'b1;
      req_ch.rx_byte <= rx;
      req_ch.buffer_end <= buf_end;
      do @(posedge clock); while (!req_ch.ready);
      gap = sender_eager ? 0 : pick_idle();
      if (hold && gap == 0) gap = 1;
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
         // hold off until the block has nothing left in flight
         while (hold && pending_results.size() != 0) @(posedge clock);
      end
   endtask

   initial begin
      stim_row_t   row;
      logic [8:0]  frame_bytes[$];
      logic [63:0] len64;
      logic [6:0]  len_code;
      logic [3:0]  op;
      logic        fin_bit, masked, cut, huge;
      bit          hold;
      int          kind, plen, cut_at, len_pick, items_sent;
      req_ch.valid <= 1'b0;
      req_ch.rx_byte <= 8'h00;
      req_ch.buffer_end <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (STIM_TABLE[i]) begin
         row = STIM_TABLE[i];
         send_byte(row.rx, row.buf_end, i == $size(STIM_TABLE) - 1,
                   row.pinned, row.pin_got, row.pin);
      end

      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         kind = $urandom_range(0, 19);
         sender_eager = ($urandom_range(0, 3) == 0);
         frame_bytes.delete();
         if (kind < 2) begin
            // line noise
            plen = $urandom_range(1, 6);
            repeat (plen)
               frame_bytes.push_back({($urandom_range(0, 7) == 0) ? 1'b1 : 1'b0,
                                      8'($urandom)});
         end else begin
            cut = (kind < 5);
            huge = cut && ($urandom_range(0, 2) == 0);
            case ($urandom_range(0, 9))
               0, 1, 2, 3: op = OP_CONT;
               4, 5, 6:    op = OP_TEXT;
               7, 8:       op = OP_BINARY;
               default:    op = 4'($urandom);
            endcase
            fin_bit = 1'($urandom);
            masked = 1'($urandom);
            if (huge) begin
               len_code = LEN_CODE_64;
               len64 = {$urandom, $urandom};
               plen = $urandom_range(0, 20);
            end else begin
               len_pick = $urandom_range(0, 19);
               if (len_pick < 12) len64 = 64'($urandom_range(0, 8));
               else if (len_pick < 15)
                  len64 = $urandom_range(0, 1) ? 64'(SHORT_LEN_MAX) :
                                                 64'($urandom_range(9, 125));
               else if (len_pick < 18) len64 = 64'($urandom_range(0, 300));
               else len64 = 64'($urandom_range(0, 40));
               if (len_pick < 15) len_code = len64[6:0];
               else if (len_pick < 18) len_code = LEN_CODE_16;
               else len_code = LEN_CODE_64;
               plen = int'(len64);
            end
            frame_bytes.push_back({1'b0, fin_bit, 3'($urandom), op});
            frame_bytes.push_back({1'b0, masked, len_code});
            if (len_code == LEN_CODE_16)
               for (int k = 1; k >= 0; k--) frame_bytes.push_back({1'b0, len64[8*k +: 8]});
            else if (len_code == LEN_CODE_64)
               for (int k = 7; k >= 0; k--) frame_bytes.push_back({1'b0, len64[8*k +: 8]});
            if (masked) repeat (4) frame_bytes.push_back({1'b0, 8'($urandom)});
            repeat (plen) frame_bytes.push_back({1'b0, 8'($urandom)});
            if (cut) begin
               cut_at = $urandom_range(0, frame_bytes.size() - 1);
               frame_bytes = frame_bytes[0:cut_at];
               frame_bytes[cut_at][8] = 1'b1;
            end else if ($urandom_range(0, 3) == 0) begin
               frame_bytes[frame_bytes.size() - 1][8] = 1'b1;
            end
         end
         hold = ($urandom_range(0, 14) == 0);
         foreach (frame_bytes[i])
            send_byte(frame_bytes[i][7:0], frame_bytes[i][8],
                      hold && i == frame_bytes.size() - 1, 1'b0, 1'b0, NO_RSP);
         items_sent += frame_bytes.size();
      end

      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      int stall;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         stall = pick_idle();
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         repeat (($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      result_t want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected transaction: status %0d payload_byte %0h",
                   rsp_ch.status, rsp_ch.payload_byte);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_ch.payload_byte !== want.payload_byte) begin
               $error("payload_byte: expected %0h, got %0h",
                      want.payload_byte, rsp_ch.payload_byte);
               mismatches++;
            end
            if (rsp_ch.message_opcode !== want.message_opcode) begin
               $error("message_opcode: expected %0h, got %0h",
                      want.message_opcode, rsp_ch.message_opcode);
               mismatches++;
            end
            if (rsp_ch.final_fragment !== want.final_fragment) begin
               $error("final_fragment: expected %0b, got %0b",
                      want.final_fragment, rsp_ch.final_fragment);
               mismatches++;
            end
            if (rsp_ch.frame_last !== want.frame_last) begin
               $error("frame_last: expected %0b, got %0b", want.frame_last, rsp_ch.frame_last);
               mismatches++;
            end
            if (rsp_ch.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
               mismatches++;
            end
         end
      end
   end

   // Abandon the run if neither channel moves for too long
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

endmodule

/* sim.f */
rtl/wsfp_pkg.sv
rtl/wsfp_req_if.sv
rtl/wsfp_rsp_if.sv
rtl/wsfp_len_acc.sv
rtl/websocket_frame_parser.sv
tb/tb_top.sv
